/* rtl/utf8_to_panel_char_folder_unit_defines.svh */
// Assertion macros shared by the folder unit.
`ifndef UTF8_TO_PANEL_CHAR_FOLDER_UNIT_DEFINES_SVH
`define UTF8_TO_PANEL_CHAR_FOLDER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define U2P_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define U2P_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define U2P_ASSERT(lbl, clk, rst_n, prop, msg)
`define U2P_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/u2p_pkg.sv */
package u2p_pkg;

    localparam int          QDEPTH    = 2;
    localparam logic [7:0]  MARKER    = 8'h15;
    localparam logic [7:0]  QMARK     = 8'h3F;
    localparam logic [7:0]  LEAD_C3   = 8'hC3;
    localparam logic [7:0]  LEAD_C4   = 8'hC4;
    localparam logic [7:0]  LEAD_C5   = 8'hC5;
    localparam logic [7:0]  LEAD_D0   = 8'hD0;
    localparam logic [7:0]  LEAD_D1   = 8'hD1;
    localparam logic [7:0]  CYR_BASE  = 8'hA0;
    localparam logic [7:0]  D0_OFFSET = 8'h20;
    localparam logic [7:0]  D1_OFFSET = 8'h60;
    localparam logic [7:0]  CASE_STEP = 8'h20;

    typedef enum logic [0:0] {
        K_PASS,
        K_FOLD
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] lead;
        logic [7:0] data;
        logic       last;
    } t_item;

    localparam logic [7:0] CYR_TABLE [96] = '{
        8'h20, 8'hA2, 8'h3F, 8'h3F, 8'h3F, 8'h53, 8'h49, 8'h49,
        8'h4A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F,
        8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
        8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
        8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
        8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
        8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
        8'hA5, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
        8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
        8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
        8'h4E, 8'hB5, 8'h3F, 8'h3F, 8'h3F, 8'h73, 8'h69, 8'h69,
        8'h6A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F
    };

    function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [7:0] by_parity(input logic [7:0] s, input logic up_par,
                                             input logic [7:0] upper);
        return (s[0] == up_par) ? upper : upper + CASE_STEP;
    endfunction

    function automatic logic [7:0] cyr_map(input logic [7:0] idx);
        logic [7:0] off;
        off = idx - CYR_BASE;
        if (idx < CYR_BASE) begin
            return idx;
        end
        return CYR_TABLE[off[6:0]];
    endfunction

    function automatic logic [7:0] fold_c3(input logic [7:0] s);
        if (in_rng(s, 8'h80, 8'h85)) return "A";
        if (in_rng(s, 8'h88, 8'h8B)) return "E";
        if (in_rng(s, 8'h8C, 8'h8F)) return "I";
        if (in_rng(s, 8'h92, 8'h96)) return "O";
        if (in_rng(s, 8'h99, 8'h9C)) return "U";
        if (in_rng(s, 8'hA0, 8'hA5)) return "a";
        if (in_rng(s, 8'hA8, 8'hAB)) return "e";
        if (in_rng(s, 8'hAC, 8'hAF)) return "i";
        if (in_rng(s, 8'hB2, 8'hB6)) return "o";
        if (in_rng(s, 8'hB9, 8'hBC)) return "u";
        return QMARK;
    endfunction

    function automatic logic [7:0] fold_c4(input logic [7:0] s);
        if (in_rng(s, 8'h80, 8'h85)) return by_parity(s, 1'b0, "A");
        if (in_rng(s, 8'h86, 8'h8D)) return by_parity(s, 1'b0, "C");
        if (in_rng(s, 8'h8E, 8'h91)) return by_parity(s, 1'b0, "D");
        if (in_rng(s, 8'h92, 8'h9B)) return by_parity(s, 1'b0, "E");
        if (in_rng(s, 8'h9C, 8'hA3)) return by_parity(s, 1'b0, "G");
        if (in_rng(s, 8'hA4, 8'hA7)) return by_parity(s, 1'b0, "H");
        if (in_rng(s, 8'hA8, 8'hB3)) return by_parity(s, 1'b0, "I");
        if (in_rng(s, 8'hB4, 8'hB5)) return by_parity(s, 1'b0, "J");
        if (in_rng(s, 8'hB6, 8'hB7)) return by_parity(s, 1'b0, "K");
        if (s == 8'hB8) return "k";
        if (in_rng(s, 8'hB9, 8'hBF)) return by_parity(s, 1'b1, "L");
        return QMARK;
    endfunction

    function automatic logic [7:0] fold_c5(input logic [7:0] s);
        if (in_rng(s, 8'h80, 8'h82)) return by_parity(s, 1'b1, "L");
        if (in_rng(s, 8'h83, 8'h88)) return by_parity(s, 1'b1, "N");
        if (s == 8'h89) return "n";
        if (in_rng(s, 8'h8A, 8'h8B)) return by_parity(s, 1'b0, "N");
        if (in_rng(s, 8'h8C, 8'h93)) return by_parity(s, 1'b0, "O");
        if (in_rng(s, 8'h94, 8'h99)) return by_parity(s, 1'b0, "R");
        if (in_rng(s, 8'h9A, 8'hA1)) return by_parity(s, 1'b0, "S");
        if (in_rng(s, 8'hA2, 8'hA7)) return by_parity(s, 1'b0, "T");
        if (in_rng(s, 8'hA8, 8'hB3)) return by_parity(s, 1'b0, "U");
        if (in_rng(s, 8'hB4, 8'hB5)) return by_parity(s, 1'b0, "W");
        if (in_rng(s, 8'hB6, 8'hB8)) return by_parity(s, 1'b0, "Y");
        if (in_rng(s, 8'hB9, 8'hBE)) return by_parity(s, 1'b1, "Z");
        return QMARK;
    endfunction

    function automatic logic [7:0] fold_pair(input logic [7:0] lead, input logic [7:0] s,
                                             input logic rus);
        logic [7:0] res;
        unique case (lead)
            LEAD_C3: res = fold_c3(s);
            LEAD_C4: res = fold_c4(s);
            LEAD_C5: res = fold_c5(s);
            LEAD_D0: res = rus ? cyr_map(s + D0_OFFSET) : QMARK;
            LEAD_D1: res = rus ? cyr_map(s + D1_OFFSET) : QMARK;
            default: res = QMARK;
        endcase
        return res;
    endfunction

endpackage

/* rtl/u2p_front.sv */
`include "utf8_to_panel_char_folder_unit_defines.svh"

module u2p_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_eos,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output u2p_pkg::t_item o_item
);
    import u2p_pkg::*;

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_pending, n_pending;
    logic       r_at_start, n_at_start;
    logic       accept;
    logic [1:0] tail_in;
    logic [1:0] tail_lead;
    logic [1:0] pend_dec;

    function automatic logic [1:0] tail_count(input logic [7:0] lead);
        if (in_rng(lead, 8'hC0, 8'hDF)) return 2'd1;
        if (in_rng(lead, 8'hE0, 8'hEF)) return 2'd2;
        if (in_rng(lead, 8'hF0, 8'hF7)) return 2'd3;
        return 2'd0;
    endfunction

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign tail_in   = tail_count(i_byte);
    assign tail_lead = tail_count(r_lead);
    assign pend_dec  = r_pending - 2'd1;

    always_comb begin
        n_lead      = r_lead;
        n_pending   = r_pending;
        n_at_start  = r_at_start;
        o_push      = 1'b0;
        o_item.kind = K_PASS;
        o_item.lead = r_lead;
        o_item.data = QMARK;
        o_item.last = i_eos;
        if (accept) begin
            if (r_pending == 2'd0) begin
                n_at_start = i_eos;
                if (r_at_start && i_byte == MARKER) begin
                    // drop the marker
                end else if (!i_byte[7]) begin
                    o_push      = 1'b1;
                    o_item.data = i_byte;
                end else if (tail_in == 2'd0 || i_eos) begin
                    o_push = 1'b1;
                end else begin
                    n_lead    = i_byte;
                    n_pending = tail_in;
                end
            end else if (pend_dec == 2'd0) begin
                o_push     = 1'b1;
                n_pending  = 2'd0;
                n_at_start = i_eos;
                if (tail_lead == 2'd1) begin
                    o_item.kind = K_FOLD;
                    o_item.data = i_byte;
                end
            end else if (i_eos) begin
                o_push     = 1'b1;
                n_pending  = 2'd0;
                n_at_start = 1'b1;
            end else begin
                n_pending = pend_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead <= n_lead;
        if (!i_rst_n) begin
            r_pending  <= 2'd0;
            r_at_start <= 1'b1;
        end else begin
            r_pending  <= n_pending;
            r_at_start <= n_at_start;
        end
    end

    `U2P_ASSERT_IMPL(a_pend_not_start, i_clk, i_rst_n, r_pending != 2'd0, !r_at_start, "start flag set mid-sequence")
    `U2P_ASSERT_IMPL(a_push_on_accept, i_clk, i_rst_n, o_push, accept, "push without accepted byte")

endmodule

/* rtl/u2p_queue.sv */
`include "utf8_to_panel_char_folder_unit_defines.svh"

module u2p_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u2p_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output u2p_pkg::t_item o_item
);
    import u2p_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_item          r_mem [QDEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `U2P_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `U2P_ASSERT(a_count_up, i_clk, i_rst_n, (i_rst_n && i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "queue count did not advance")

endmodule

/* rtl/u2p_back.sv */
`include "utf8_to_panel_char_folder_unit_defines.svh"

module u2p_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_q_valid,
    input  u2p_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_char,
    output logic           o_last
);
    import u2p_pkg::*;

    logic       r_rus;
    logic       r_valid, n_valid;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;

    assign o_pop   = i_q_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

    always_comb begin
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_last  = r_last;
        if (o_pop) begin
            n_valid = 1'b1;
            n_last  = i_item.last;
            n_char  = (i_item.kind == K_FOLD) ? fold_pair(i_item.lead, i_item.data, r_rus)
                                              : i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        if (!i_rst_n) begin
            r_rus   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_rus <= i_cfg_wdata;
            end
        end
    end

    `U2P_ASSERT(a_pop_loads, i_clk, i_rst_n, (i_rst_n && o_pop) |=> r_valid, "popped item not presented")

endmodule

/* rtl/utf8_to_panel_char_folder_unit.sv */
// UTF-8 to panel character folder.
// Input stream: one source byte per transaction on i_s_tdata, i_s_tlast marks
// the final byte of a string. Output stream: one panel character per decoded
// source character on o_m_tdata, o_m_tlast marks the final character.
// A marker byte 0x15 at the start of a string and the leading bytes of a
// multi-byte character produce no output transaction.
// Throughput: one byte per cycle unless the queue is full; the front
// classifier tracks the multi-byte sequence state and hands items through a
// two-entry queue to the fold stage, which registers the result.
// An accepted byte is written into the queue, then popped, folded and
// captured in the output register, which presents its character to the
// receiver.
// When the receiver holds i_m_tready low, the output register holds its
// transaction, the queue fills, and o_s_tready falls once two items wait.
// Reset (i_rst_n low, synchronous) empties the queue and the output register,
// clears the Russian mode bit and returns to the start of a string.
// i_cfg_we writes i_cfg_wdata into the Russian mode bit; write it while idle.
module utf8_to_panel_char_folder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] panel_char
    output logic       o_m_tlast
);
    import u2p_pkg::*;

    t_item q_in_item, q_out_item;
    logic  q_push, q_full, q_pop, q_valid;

    u2p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_eos   (i_s_tlast),
        .i_full  (q_full),
        .o_ready (o_s_tready),
        .o_push  (q_push),
        .o_item  (q_in_item)
    );

    u2p_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    u2p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_item      (q_out_item),
        .o_pop       (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_char      (o_m_tdata),
        .o_last      (o_m_tlast)
    );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

package folder_tb_pkg;

    localparam logic [7:0] MARKER_BYTE   = 8'h15;
    localparam logic [7:0] ASCII_TOP     = 8'h7F;
    localparam logic [7:0] UNKNOWN_GLYPH = 8'h3F;
    localparam logic [7:0] LEAD_C3       = 8'hC3;
    localparam logic [7:0] LEAD_C4       = 8'hC4;
    localparam logic [7:0] LEAD_C5       = 8'hC5;
    localparam logic [7:0] LEAD_D0       = 8'hD0;
    localparam logic [7:0] LEAD_D1       = 8'hD1;
    localparam logic [7:0] CYR_FIRST     = 8'hA0;
    localparam logic [7:0] D0_SHIFT      = 8'h20;
    localparam logic [7:0] D1_SHIFT      = 8'h60;
    localparam int         MAX_REPORTS   = 40;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } panel_char_t;

    class panel_scoreboard;
        logic [7:0]  seq_lead;
        logic [7:0]  seq_second;
        logic [1:0]  tail_left;
        bit          fresh_string;
        bit          russian;
        logic [7:0]  cyr_glyph [96];
        panel_char_t due [$];
        int          mismatches;
        int          chars_checked;

        function new();
            seq_lead      = 8'h00;
            seq_second    = 8'h00;
            tail_left     = 2'd0;
            fresh_string  = 1'b1;
            russian       = 1'b0;
            mismatches    = 0;
            chars_checked = 0;
            cyr_glyph = '{
                8'h20, 8'hA2, 8'h3F, 8'h3F, 8'h3F, 8'h53, 8'h49, 8'h49,
                8'h4A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F,
                8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
                8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
                8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
                8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
                8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
                8'hA5, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
                8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
                8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7,
                8'h4E, 8'hB5, 8'h3F, 8'h3F, 8'h3F, 8'h73, 8'h69, 8'h69,
                8'h6A, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'hCC, 8'h3F
            };
        endfunction

        function bit spans(input logic [7:0] v, input logic [7:0] lo, input logic [7:0] hi);
            return (v >= lo) && (v <= hi);
        endfunction

        // lowercase sets bit 5 whenever the low bit differs from the uppercase parity
        function logic [7:0] fold_case(input logic [7:0] s, input logic odd_upper,
                                       input logic [7:0] base);
            return {base[7:6], s[0] ^ odd_upper, base[4:0]};
        endfunction

        function logic [1:0] tail_len(input logic [7:0] b);
            if (spans(b, 8'hC0, 8'hDF)) return 2'd1;
            if (spans(b, 8'hE0, 8'hEF)) return 2'd2;
            if (spans(b, 8'hF0, 8'hF7)) return 2'd3;
            return 2'd0;
        endfunction

        function void push_char(input logic [7:0] code, input logic last);
            panel_char_t c;
            c.code = code;
            c.last = last;
            due.push_back(c);
            if (last) fresh_string = 1'b1;
        endfunction

        function void note_byte(input logic [7:0] b, input logic eos);
            logic [7:0] glyph;
            logic [7:0] s;
            logic [7:0] idx;
            logic [1:0] tail;
            if (tail_left == 2'd0) begin
                if (fresh_string && b == MARKER_BYTE) begin
                    fresh_string = eos;
                    return;
                end
                fresh_string = 1'b0;
                tail = tail_len(b);
                if (b <= ASCII_TOP) begin
                    push_char(b, eos);
                end else if (tail == 2'd0 || eos) begin
                    push_char(UNKNOWN_GLYPH, eos);
                end else begin
                    seq_lead  = b;
                    tail_left = tail;
                end
                return;
            end
            if (tail_left == tail_len(seq_lead)) seq_second = b;
            tail_left = tail_left - 2'd1;
            if (tail_left != 2'd0) begin
                if (eos) begin
                    tail_left = 2'd0;
                    push_char(UNKNOWN_GLYPH, 1'b1);
                end
                return;
            end
            glyph = UNKNOWN_GLYPH;
            s = seq_second;
            if (tail_len(seq_lead) == 2'd1) begin
                case (seq_lead)
                    LEAD_C3: begin
                        if      (spans(s, 8'h80, 8'h85)) glyph = "A";
                        else if (spans(s, 8'h88, 8'h8B)) glyph = "E";
                        else if (spans(s, 8'h8C, 8'h8F)) glyph = "I";
                        else if (spans(s, 8'h92, 8'h96)) glyph = "O";
                        else if (spans(s, 8'h99, 8'h9C)) glyph = "U";
                        else if (spans(s, 8'hA0, 8'hA5)) glyph = "a";
                        else if (spans(s, 8'hA8, 8'hAB)) glyph = "e";
                        else if (spans(s, 8'hAC, 8'hAF)) glyph = "i";
                        else if (spans(s, 8'hB2, 8'hB6)) glyph = "o";
                        else if (spans(s, 8'hB9, 8'hBC)) glyph = "u";
                    end
                    LEAD_C4: begin
                        if      (spans(s, 8'h80, 8'h85)) glyph = fold_case(s, 1'b0, "A");
                        else if (spans(s, 8'h86, 8'h8D)) glyph = fold_case(s, 1'b0, "C");
                        else if (spans(s, 8'h8E, 8'h91)) glyph = fold_case(s, 1'b0, "D");
                        else if (spans(s, 8'h92, 8'h9B)) glyph = fold_case(s, 1'b0, "E");
                        else if (spans(s, 8'h9C, 8'hA3)) glyph = fold_case(s, 1'b0, "G");
                        else if (spans(s, 8'hA4, 8'hA7)) glyph = fold_case(s, 1'b0, "H");
                        else if (spans(s, 8'hA8, 8'hB3)) glyph = fold_case(s, 1'b0, "I");
                        else if (spans(s, 8'hB4, 8'hB5)) glyph = fold_case(s, 1'b0, "J");
                        else if (spans(s, 8'hB6, 8'hB7)) glyph = fold_case(s, 1'b0, "K");
                        else if (s == 8'hB8)             glyph = "k";
                        else if (spans(s, 8'hB9, 8'hBF)) glyph = fold_case(s, 1'b1, "L");
                    end
                    LEAD_C5: begin
                        if      (spans(s, 8'h80, 8'h82)) glyph = fold_case(s, 1'b1, "L");
                        else if (spans(s, 8'h83, 8'h88)) glyph = fold_case(s, 1'b1, "N");
                        else if (s == 8'h89)             glyph = "n";
                        else if (spans(s, 8'h8A, 8'h8B)) glyph = fold_case(s, 1'b0, "N");
                        else if (spans(s, 8'h8C, 8'h93)) glyph = fold_case(s, 1'b0, "O");
                        else if (spans(s, 8'h94, 8'h99)) glyph = fold_case(s, 1'b0, "R");
                        else if (spans(s, 8'h9A, 8'hA1)) glyph = fold_case(s, 1'b0, "S");
                        else if (spans(s, 8'hA2, 8'hA7)) glyph = fold_case(s, 1'b0, "T");
                        else if (spans(s, 8'hA8, 8'hB3)) glyph = fold_case(s, 1'b0, "U");
                        else if (spans(s, 8'hB4, 8'hB5)) glyph = fold_case(s, 1'b0, "W");
                        else if (spans(s, 8'hB6, 8'hB8)) glyph = fold_case(s, 1'b0, "Y");
                        else if (spans(s, 8'hB9, 8'hBE)) glyph = fold_case(s, 1'b1, "Z");
                    end
                    LEAD_D0, LEAD_D1: begin
                        if (russian) begin
                            idx = s + ((seq_lead == LEAD_D0) ? D0_SHIFT : D1_SHIFT);
                            glyph = (idx < CYR_FIRST) ? idx : cyr_glyph[idx - CYR_FIRST];
                        end
                    end
                    default: glyph = UNKNOWN_GLYPH;
                endcase
            end
            push_char(glyph, eos);
        endfunction

        function void check_char(input logic [7:0] code, input logic last);
            panel_char_t want;
            chars_checked++;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: panel_char/last_char expected none, actual %02h/%0b",
                             $time, code, last);
                return;
            end
            want = due.pop_front();
            if (code !== want.code) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: panel_char expected %02h, actual %02h",
                             $time, want.code, code);
            end
            if (last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: last_char expected %0b, actual %0b",
                             $time, want.last, last);
            end
        endfunction
    endclass

endpackage

module tb;
    import folder_tb_pkg::*;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_style_e;
    typedef enum {
        GL_ASCII, GL_LATIN, GL_CYRILLIC, GL_OTHER_PAIR,
        GL_WIDE, GL_ASTRAL, GL_BAD_LEAD, GL_NOISE
    } glyph_kind_e;

    localparam int LONG_HOLD     = 90;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int PHASES        = 8;
    localparam int RANDOM_BYTES  = 1030;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_s_tvalid  = 1'b0;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       i_s_tlast   = 1'b0;
    logic       i_m_tready  = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;

    panel_scoreboard sb;
    logic [7:0]      text [$];
    int              burst_left = 0;
    int              bytes_sent = 0;
    int              cfg_writes = 0;
    int              hold_ticket = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    int              style_left = 0;
    int              rx_tick = 0;
    rx_style_e       rx_style = RX_OPEN;

    utf8_to_panel_char_folder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_char(o_m_tdata, o_m_tlast);
    end

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        int v;
        v = $urandom_range(hi, lo);
        return v[7:0];
    endfunction

    function automatic logic [7:0] tail_byte();
        return ($urandom_range(7, 0) == 0) ? rand_byte(0, 255) : rand_byte(8'h80, 8'hBF);
    endfunction

    always @(posedge i_clk) begin
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD;
        end
        if (style_left == 0) begin
            rx_style   = rx_style_e'($urandom_range(3, 0));
            style_left = $urandom_range(120, 16);
        end else begin
            style_left--;
        end
        rx_tick++;
        if (hold_left != 0) begin
            // hold the output for a long stretch
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_OPEN:   i_m_tready <= 1'b1;
                RX_COIN:   i_m_tready <= (rand_byte(0, 1) != 0);
                RX_SPARSE: i_m_tready <= (rx_tick % 4 == 0);
                default:   i_m_tready <= (rx_tick % 9 < 6);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 60)
                                                     : $urandom_range(24, 1);
            gap = $urandom_range(6, 1);
            // drop valid for the gap
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= eos;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_byte(b, eos);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int k = 0; k < text.size(); k++) send_byte(text[k], k == text.size() - 1);
    endtask

    task automatic send_random_string();
        int          n_glyphs;
        int          roll;
        glyph_kind_e kind;
        text.delete();
        if ($urandom_range(3, 0) == 0) text.push_back(MARKER_BYTE);
        n_glyphs = $urandom_range(10, 1);
        for (int g = 0; g < n_glyphs; g++) begin
            roll = $urandom_range(99, 0);
            kind = (roll < 25) ? GL_ASCII :
                   (roll < 50) ? GL_LATIN :
                   (roll < 68) ? GL_CYRILLIC :
                   (roll < 74) ? GL_OTHER_PAIR :
                   (roll < 80) ? GL_WIDE :
                   (roll < 85) ? GL_ASTRAL :
                   (roll < 92) ? GL_BAD_LEAD : GL_NOISE;
            case (kind)
                GL_ASCII: text.push_back(rand_byte(0, 127));
                GL_LATIN: begin
                    text.push_back(rand_byte(LEAD_C3, LEAD_C5));
                    text.push_back(tail_byte());
                end
                GL_CYRILLIC: begin
                    text.push_back(rand_byte(LEAD_D0, LEAD_D1));
                    text.push_back(tail_byte());
                end
                GL_OTHER_PAIR: begin
                    text.push_back(rand_byte(8'hC0, 8'hDF));
                    text.push_back(tail_byte());
                end
                GL_WIDE: begin
                    text.push_back(rand_byte(8'hE0, 8'hEF));
                    for (int n = 0; n < 2; n++) text.push_back(tail_byte());
                end
                GL_ASTRAL: begin
                    text.push_back(rand_byte(8'hF0, 8'hF7));
                    for (int n = 0; n < 3; n++) text.push_back(tail_byte());
                end
                GL_BAD_LEAD: begin
                    text.push_back((rand_byte(0, 1) != 0) ? rand_byte(8'h80, 8'hBF)
                                                          : rand_byte(8'hF8, 8'hFF));
                end
                default: text.push_back(rand_byte(0, 255));
            endcase
        end
        // cut the tail so the string may end inside a character
        if ($urandom_range(7, 0) == 0 && text.size() > 1) void'(text.pop_back());
        send_text();
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (sb.due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_russian(input logic on);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= on;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.russian = on;
        cfg_writes++;
    endtask

    initial begin
        int phase_end;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_russian(1'b0);
        text = '{MARKER_BYTE, 8'h00, MARKER_BYTE, LEAD_C3, 8'hA9, LEAD_C5, 8'hA2,
                 LEAD_D0, 8'h96, 8'hE2, 8'h82};
        send_text();
        text = '{8'hFF, LEAD_C4};
        send_text();

        set_russian(1'b1);
        text = '{MARKER_BYTE};
        send_text();
        text = '{LEAD_D0, 8'h90, LEAD_D1, 8'h8F, LEAD_D0, 8'h00, LEAD_D1, 8'hFF, ASCII_TOP};
        send_text();

        for (int phase = 0; phase < PHASES; phase++) begin
            set_russian(phase[0]);
            if (phase == 2 || phase == 5) hold_ticket++;
            phase_end = bytes_sent + RANDOM_BYTES / PHASES;
            while (bytes_sent < phase_end) send_random_string();
        end

        settle();
        if (sb.due.size() != 0) begin
            sb.mismatches++;
            $display("%0t: %0d characters expected, none arrived; first expected %02h/%0b",
                     $time, sb.due.size(), sb.due[0].code, sb.due[0].last);
        end
        $display("Folded %0d source bytes into %0d panel characters across %0d mode writes,",
                 bytes_sent, sb.chars_checked, cfg_writes);
        $display("with markers, truncations, multi-byte leads and long output holds.");
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
